### rtl/assert_macros.svh
// Assertion macros used by the occupancy counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

### rtl/tsoc_pkg.sv
// Types and constants of the two-sensor occupancy counter.
package tsoc_pkg;

  // Configuration port geometry and register indexes.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgEntryHold  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgExitHold   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWatchWindow = 2'd2;

  // Register reset values.
  localparam logic [7:0]  EntryHoldRst   = 8'd40;
  localparam logic [7:0]  ExitHoldRst    = 8'd20;
  localparam logic [15:0] WatchWindowRst = 16'd400;

  // Upper bound of the occupant count; the 8-bit count also stops at 255.
  localparam int unsigned CountMax = 255;
  localparam logic [7:0] PeopleLimit = (CountMax < 255) ? 8'(CountMax) : 8'd255;

  typedef struct packed {
    logic sensor_door;
    logic sensor_room;
    logic enabled;
    logic step_watch;
    logic step_entry;
    logic step_exit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] occupancy_count;
    logic       entry_pending;
    logic       exit_pending;
    logic       entry_locked;
    logic       exit_locked;
  } out_item_t;

  // Status of one polling machine as seen by the rest of the block.
  typedef struct packed {
    logic lock;
    logic pending;
  } poller_status_t;

endpackage

### rtl/tsoc_stream_if.sv
// Valid/ready channel carrying one payload item per transfer.
interface tsoc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/tsoc_poller.sv
// Polling machine that detects one sensor, locks the other side and holds pending.
module tsoc_poller (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic                    sense_i,
  input  logic                    other_lock_i,
  input  logic [7:0]              hold_i,
  output tsoc_pkg::poller_status_t status_o,
  output logic                    lock_next_o
);

  typedef enum logic [1:0] {
    PhInit     = 2'd0,
    PhPoll     = 2'd1,
    PhValidate = 2'd2,
    PhStop     = 2'd3
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] timer_q, timer_d;
  logic       lock_q, lock_d;
  logic       pending_q, pending_d;

  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    lock_d    = lock_q;
    pending_d = pending_q;
    if (step_i) begin
      case (phase_q)
        PhInit: begin
          timer_d   = 8'd0;
          lock_d    = 1'b0;
          pending_d = 1'b0;
          phase_d   = PhPoll;
        end
        PhPoll: begin
          if (other_lock_i) begin
            phase_d = PhStop;
          end else if (sense_i) begin
            lock_d  = 1'b1;
            phase_d = PhValidate;
          end else begin
            phase_d = PhPoll;
          end
        end
        PhValidate: begin
          pending_d = 1'b1;
          if (timer_q < hold_i) begin
            timer_d = timer_q + 8'd1;
          end else begin
            timer_d   = 8'd0;
            pending_d = 1'b0;
            lock_d    = 1'b0;
            phase_d   = PhPoll;
          end
        end
        PhStop: begin
          phase_d = other_lock_i ? PhStop : PhPoll;
        end
        default: begin
          phase_d = PhInit;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhInit;
      timer_q   <= 8'd0;
      lock_q    <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      lock_q    <= lock_d;
      pending_q <= pending_d;
    end
  end

  assign status_o.lock    = lock_q;
  assign status_o.pending = pending_q;
  assign lock_next_o      = lock_d;

endmodule

### rtl/tsoc_watcher.sv
// Confirming machine that samples the opposite sensor and moves the occupant count.
module tsoc_watcher (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic                     sensor_door_i,
  input  logic                     sensor_room_i,
  input  tsoc_pkg::poller_status_t entry_i,
  input  tsoc_pkg::poller_status_t exit_i,
  input  logic [15:0]              window_i,
  output logic [7:0]               people_o
);

  typedef enum logic [1:0] {
    WpInit = 2'd0,
    WpWait = 2'd1,
    WpDec  = 2'd2,
    WpInc  = 2'd3
  } watch_phase_e;

  watch_phase_e phase_q, phase_d;
  logic [15:0]  timer_q, timer_d;
  logic         hit_q, hit_d;
  logic [7:0]   people_q, people_d;
  logic         sample;

  assign sample = (phase_q == WpInc) ? sensor_room_i : sensor_door_i;

  always_comb begin
    phase_d  = phase_q;
    timer_d  = timer_q;
    hit_d    = hit_q;
    people_d = people_q;
    if (step_i) begin
      case (phase_q)
        WpInit: begin
          hit_d    = 1'b0;
          timer_d  = 16'd0;
          people_d = 8'd0;
          phase_d  = WpWait;
        end
        WpWait: begin
          if (entry_i.pending && !exit_i.pending) begin
            phase_d = WpInc;
          end else if (!entry_i.pending && exit_i.pending) begin
            phase_d = WpDec;
          end
        end
        WpDec, WpInc: begin
          if (timer_q < window_i) begin
            timer_d = timer_q + 16'd1;
            if (sample) begin
              hit_d = 1'b1;
            end
          end else begin
            timer_d = 16'd0;
            if (hit_q) begin
              if (phase_q == WpInc) begin
                if (people_q < tsoc_pkg::PeopleLimit) begin
                  people_d = people_q + 8'd1;
                end
              end else if (people_q != 8'd0) begin
                people_d = people_q - 8'd1;
              end
            end
            hit_d   = 1'b0;
            phase_d = WpWait;
          end
        end
        default: begin
          phase_d = WpInit;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= WpInit;
      timer_q  <= 16'd0;
      hit_q    <= 1'b0;
      people_q <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      timer_q  <= timer_d;
      hit_q    <= hit_d;
      people_q <= people_d;
    end
  end

  assign people_o = people_q;

endmodule

### rtl/two_sensor_occupancy_counter_core.sv
// Top level of the two-sensor occupancy counter: channels, configuration and sequencing.
// Path: a result is offered once its tick has passed the input register and then
//   the machine state registers, which double as the result register.
// Throughput: one item per cycle (single input register) while the sink is ready.
// Reset (rst_ni low, asynchronous): all machines return to their init phase, the count
//   clears, both channels go empty and the registers take 40, 20 and 400.
module two_sensor_occupancy_counter_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tsoc_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [tsoc_pkg::CfgDataW-1:0]         cfg_data_i,
  tsoc_stream_if.sink                           item_i,
  tsoc_stream_if.source                         result_o
);

`include "assert_macros.svh"

  // Configuration registers. Writes land at once; the block is idle by contract.
  logic [7:0]  entry_hold_q;
  logic [7:0]  exit_hold_q;
  logic [15:0] watch_window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_hold_q   <= tsoc_pkg::EntryHoldRst;
      exit_hold_q    <= tsoc_pkg::ExitHoldRst;
      watch_window_q <= tsoc_pkg::WatchWindowRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsoc_pkg::CfgEntryHold:   entry_hold_q   <= cfg_data_i[7:0];
        tsoc_pkg::CfgExitHold:    exit_hold_q    <= cfg_data_i[7:0];
        tsoc_pkg::CfgWatchWindow: watch_window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register. The tick moves into the machines when the result slot is free
  // or is being emptied in the same cycle, so a new transfer can follow every cycle.
  tsoc_pkg::in_item_t in_q;
  logic               in_valid_q, in_valid_d;
  logic               out_valid_q, out_valid_d;
  logic               advance;
  logic               in_fire;

  assign advance     = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;
  assign in_fire     = item_i.valid && item_i.ready;
  assign in_valid_d  = in_fire || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= item_i.payload;
    end
  end

  // Step enables for this tick. The watcher steps first and sees the pending flags
  // left by the previous tick; entry steps next against the exit lock as it was;
  // exit steps last against the entry lock that entry has just produced.
  logic                     watch_step;
  logic                     entry_step;
  logic                     exit_step;
  tsoc_pkg::poller_status_t entry_st;
  tsoc_pkg::poller_status_t exit_st;
  logic                     entry_lock_next;
  logic                     exit_lock_next;
  logic [7:0]               people;

  assign watch_step = advance && in_q.step_watch;
  assign entry_step = advance && in_q.enabled && in_q.step_entry;
  assign exit_step  = advance && in_q.enabled && in_q.step_exit;

  tsoc_watcher u_watcher (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (watch_step),
    .sensor_door_i (in_q.sensor_door),
    .sensor_room_i (in_q.sensor_room),
    .entry_i       (entry_st),
    .exit_i        (exit_st),
    .window_i      (watch_window_q),
    .people_o      (people)
  );

  tsoc_poller u_entry (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (entry_step),
    .sense_i      (in_q.sensor_door),
    .other_lock_i (exit_st.lock),
    .hold_i       (entry_hold_q),
    .status_o     (entry_st),
    .lock_next_o  (entry_lock_next)
  );

  tsoc_poller u_exit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (exit_step),
    .sense_i      (in_q.sensor_room),
    .other_lock_i (entry_lock_next),
    .hold_i       (exit_hold_q),
    .status_o     (exit_st),
    .lock_next_o  (exit_lock_next)
  );

  // The machine state only changes when a tick moves into the result slot, so the
  // state registers hold the pending result steady while the sink stalls.
  assign result_o.valid                   = out_valid_q;
  assign result_o.payload.occupancy_count = people;
  assign result_o.payload.entry_pending   = entry_st.pending;
  assign result_o.payload.exit_pending    = exit_st.pending;
  assign result_o.payload.entry_locked    = entry_st.lock;
  assign result_o.payload.exit_locked     = exit_st.lock;

  // Only one side can hold the lock at a time, also across the same-tick ordering.
  `ASSERT_NEVER(a_locks_exclusive, clk_i, rst_ni, entry_lock_next && exit_lock_next, "both locks set")
  // A pending flag is only raised while its own lock is held.
  `ASSERT_PROP(a_pending_locked, clk_i, rst_ni, (!entry_st.pending || entry_st.lock) && (!exit_st.pending || exit_st.lock), "pending without lock")
  // The count moves only when a tick enters the result slot.
  `ASSERT_PROP(a_people_stable, clk_i, rst_ni, !advance |=> $stable(people), "count moved without a tick")
  // The count never passes its limit.
  `ASSERT_PROP(a_people_limit, clk_i, rst_ni, people <= tsoc_pkg::PeopleLimit, "count above limit")

endmodule

### bench/tb_two_sensor_occupancy_counter_core.sv
// Self-checking testbench of the two-sensor occupancy counter core.
module tb_two_sensor_occupancy_counter_core;
  import tsoc_pkg::*;

  // The configuration port has a fourth index that maps to no register.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // Cycles without any transfer on either channel before the run is abandoned.
  // The longest correct pause is the forced receiver hold-off of LongHoldOff.
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned LongHoldOff   = 400;
  localparam int unsigned DrainCycles   = 6;

  // Phases of one polling machine and of the confirming watcher.
  typedef enum logic [1:0] {PollInit, PollScan, PollValidate, PollStop} poll_ph_e;
  typedef enum logic [1:0] {WatchInit, WatchIdle, WatchDown, WatchUp} watch_ph_e;

  typedef struct {
    poll_ph_e   ph;
    logic       seen;
    logic [7:0] timer;
    logic       lock;
    logic       pend;
  } poller_t;

  // Predicts the block's status after each accepted tick and checks the results in order.
  class occupancy_tracker;
    logic [7:0]  entry_hold;
    logic [7:0]  exit_hold;
    logic [15:0] watch_window;
    poller_t     entry_m;
    poller_t     exit_m;
    watch_ph_e   watch_ph;
    logic [15:0] watch_timer;
    logic        watch_hit;
    logic [7:0]  people;
    out_item_t   status_due[$];
    int unsigned mismatches;
    int unsigned reported;

    function new();
      entry_hold   = EntryHoldRst;
      exit_hold    = ExitHoldRst;
      watch_window = WatchWindowRst;
      entry_m      = '{PollInit, 1'b0, 8'd0, 1'b0, 1'b0};
      exit_m       = entry_m;
      watch_ph     = WatchInit;
      watch_timer  = '0;
      watch_hit    = 1'b0;
      people       = '0;
      mismatches   = 0;
      reported     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgEntryHold:   entry_hold = data[7:0];
        CfgExitHold:    exit_hold = data[7:0];
        CfgWatchWindow: watch_window = data[15:0];
        default: ;
      endcase
    endfunction

    function poller_t poll_step(poller_t m, logic sense, logic other_lock, logic [7:0] hold);
      case (m.ph)
        PollInit: begin
          m = '{PollScan, 1'b0, 8'd0, 1'b0, 1'b0};
        end
        PollScan: begin
          m.seen = sense;
          if (sense && !other_lock) begin
            m.lock = 1'b1;
            m.ph   = PollValidate;
          end else if (!sense && !other_lock) begin
            m.ph = PollScan;
          end else begin
            m.ph = PollStop;
          end
        end
        PollValidate: begin
          m.pend = 1'b1;
          if (m.timer < hold) begin
            m.timer = m.timer + 8'd1;
          end else begin
            m.timer = '0;
            m.pend  = 1'b0;
            m.lock  = 1'b0;
            m.ph    = PollScan;
          end
        end
        default: begin
          m.ph = other_lock ? PollStop : PollScan;
        end
      endcase
      return m;
    endfunction

    function void watch_step(logic door, logic room);
      logic sample;
      case (watch_ph)
        WatchInit: begin
          watch_hit   = 1'b0;
          watch_timer = '0;
          people      = '0;
          watch_ph    = WatchIdle;
        end
        WatchIdle: begin
          // Only one pending flag on its own starts a confirmation window.
          if (entry_m.pend && !exit_m.pend) watch_ph = WatchUp;
          else if (!entry_m.pend && exit_m.pend) watch_ph = WatchDown;
        end
        default: begin
          sample = (watch_ph == WatchUp) ? room : door;
          if (watch_timer < watch_window) begin
            watch_timer = watch_timer + 16'd1;
            if (sample) watch_hit = 1'b1;
          end else begin
            watch_timer = '0;
            if (watch_hit) begin
              if (watch_ph == WatchUp) begin
                if (people < PeopleLimit) people = people + 8'd1;
              end else if (people > 0) begin
                people = people - 8'd1;
              end
            end
            watch_hit = 1'b0;
            watch_ph  = WatchIdle;
          end
        end
      endcase
    endfunction

    // The watcher steps first, then entry, then exit, which sees the fresh entry lock.
    function void take_tick(in_item_t t);
      out_item_t st;
      if (t.step_watch) watch_step(t.sensor_door, t.sensor_room);
      if (t.enabled && t.step_entry)
        entry_m = poll_step(entry_m, t.sensor_door, exit_m.lock, entry_hold);
      if (t.enabled && t.step_exit)
        exit_m = poll_step(exit_m, t.sensor_room, entry_m.lock, exit_hold);
      st.occupancy_count = people;
      st.entry_pending   = entry_m.pend;
      st.exit_pending    = exit_m.pend;
      st.entry_locked    = entry_m.lock;
      st.exit_locked     = exit_m.lock;
      status_due.push_back(st);
    endfunction

    function void report(string field, logic [7:0] want_v, logic [7:0] got_v);
      mismatches++;
      if (reported < 40) begin
        reported++;
        $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
      end
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (status_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transfer, expected none got count %0d",
                 $time, got.occupancy_count);
        return;
      end
      want = status_due.pop_front();
      if (got.occupancy_count !== want.occupancy_count)
        report("occupancy_count", want.occupancy_count, got.occupancy_count);
      if (got.entry_pending !== want.entry_pending)
        report("entry_pending", want.entry_pending, got.entry_pending);
      if (got.exit_pending !== want.exit_pending)
        report("exit_pending", want.exit_pending, got.exit_pending);
      if (got.entry_locked !== want.entry_locked)
        report("entry_locked", want.entry_locked, got.entry_locked);
      if (got.exit_locked !== want.exit_locked)
        report("exit_locked", want.exit_locked, got.exit_locked);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  tsoc_stream_if #(.payload_t(in_item_t))  item_ch ();
  tsoc_stream_if #(.payload_t(out_item_t)) result_ch ();

  two_sensor_occupancy_counter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_ch),
    .result_o   (result_ch)
  );

  occupancy_tracker tracker = new();

  // The stimulus asks for long receiver hold-offs by bumping the first counter;
  // the receiver serves each request once and bumps the second.
  int unsigned hold_off_asked  = 0;
  int unsigned hold_off_served = 0;

  // Sensor levels of the random part stay put for several ticks, like real motion.
  logic door_lvl = 1'b0;
  logic room_lvl = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Receiver: checks each result transfer, then at the end of each run picks the next ready level.
  // Runs are mostly short and mixed, sometimes long with ready low or long with no idling.
  initial begin
    int unsigned run_left;
    int unsigned r;
    logic        next_ready;
    run_left        = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_ch.valid && result_ch.ready) tracker.check_status(result_ch.payload);
      if (run_left == 0) begin
        r = $urandom_range(0, 99);
        if (hold_off_served != hold_off_asked) begin
          hold_off_served++;
          next_ready = 1'b0;
          run_left   = LongHoldOff;
        end else if (r < 8) begin
          next_ready = 1'b1;
          run_left   = $urandom_range(40, 120);
        end else if (r < 14) begin
          next_ready = 1'b0;
          run_left   = $urandom_range(15, 50);
        end else begin
          next_ready = ($urandom_range(0, 99) < 70);
          run_left   = $urandom_range(1, 3);
        end
        result_ch.ready <= next_ready;
        run_left = run_left - 1;
      end else begin
        run_left = run_left - 1;
      end
    end
  end

  // Watchdog: a run that stops moving for too long has hung.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("tb_two_sensor_occupancy_counter_core: errors");
        $finish;
      end
    end
  end

  // Offers one tick and returns at the edge where it is transferred. The caller either
  // offers the next tick at once, so valid stays high, or pauses the sender.
  task automatic send_tick(input in_item_t t);
    item_ch.valid   <= 1'b1;
    item_ch.payload <= t;
    do @(posedge clk_i); while (!item_ch.ready);
    tracker.take_tick(t);
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n == 0) return;
    item_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Mostly coherent sensor activity with random step and enable flags, some pure noise.
  function automatic in_item_t next_tick();
    in_item_t t;
    if ($urandom_range(0, 9) == 0) return in_item_t'($urandom_range(0, 63));
    if ($urandom_range(0, 7) == 0) door_lvl = ~door_lvl;
    if ($urandom_range(0, 7) == 0) room_lvl = ~room_lvl;
    t.sensor_door = door_lvl;
    t.sensor_room = room_lvl;
    t.enabled     = ($urandom_range(0, 19) != 0);
    t.step_watch  = ($urandom_range(0, 9) < 7);
    t.step_entry  = ($urandom_range(0, 9) < 7);
    t.step_exit   = ($urandom_range(0, 9) < 7);
    return t;
  endfunction

  task automatic run_random(input int unsigned count, input bit back_to_back);
    repeat (count) begin
      send_tick(next_tick());
      if (!back_to_back) pause_sender(gap_len());
    end
  endtask

  // Stops offering and waits until every expected status has come back, plus a margin
  // so that the block holds nothing in flight.
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.status_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes all registers while the block is idle. Bits above a register's width are
  // filled at random, and the unused index is written too; both must be ignored.
  task automatic program_regs(input logic [7:0] e_hold, input logic [7:0] x_hold,
                              input logic [15:0] window);
    logic [CfgIdxW-1:0]  idx_list [4];
    logic [CfgDataW-1:0] data_list [4];
    drain();
    idx_list  = '{CfgEntryHold, CfgExitHold, CfgWatchWindow, CfgUnused};
    data_list = '{{8'($urandom), e_hold}, {8'($urandom), x_hold}, window, 16'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx_list[i];
      cfg_data_i <= data_list[i];
      tracker.write_reg(idx_list[i], data_list[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drives the count up to its ceiling: both sensors active, entry and the watcher
  // stepping every tick, exit frozen once it has settled back to polling.
  task automatic fill_count();
    in_item_t    t;
    int unsigned extra;
    int unsigned guard;
    repeat (6) send_tick(in_item_t'(6'b001111));
    extra = 0;
    guard = 0;
    while (extra < 30 && guard < 3000) begin
      t = in_item_t'(6'b111110);
      if ($urandom_range(0, 19) == 0) t = in_item_t'($urandom_range(0, 63));
      send_tick(t);
      if ($urandom_range(0, 9) == 0) pause_sender($urandom_range(1, 3));
      if (tracker.people == PeopleLimit) extra++;
      guard++;
    end
  endtask

  // Fields packed as {door, room, enabled, step_watch, step_entry, step_exit}.
  localparam logic [5:0] DirectedTicks [20] = '{
    6'b000000, 6'b001111, 6'b110111, 6'b101011, 6'b101111,
    6'b011111, 6'b011111, 6'b010100, 6'b000111, 6'b111111,
    6'b111000, 6'b001001, 6'b011001, 6'b010111, 6'b100101,
    6'b001110, 6'b111111, 6'b000001, 6'b110000, 6'b001111
  };

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CfgEntryHold;
    cfg_data_i      = '0;
    item_ch.valid   = 1'b0;
    item_ch.payload = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks under the reset register values: the init step of every machine,
    // frozen machines while disabled, lockout of exit by entry, and flag extremes.
    foreach (DirectedTicks[i]) begin
      send_tick(in_item_t'(DirectedTicks[i]));
      if (i % 4 == 3) pause_sender(2);
    end

    // Short holds and windows let whole entry and exit sequences complete.
    program_regs(8'd1, 8'd2, 16'd2);
    run_random(80, 1'b0);

    // Smallest settings: pending flags never show and windows close at once.
    program_regs(8'd0, 8'd0, 16'd0);
    run_random(40, 1'b0);

    // Largest settings: long pending stretches and a window that does not close within the run.
    program_regs(8'd255, 8'd255, 16'hFFFF);
    run_random(40, 1'b0);

    // Moderate settings with a long receiver hold-off while the sender keeps offering,
    // so the block fills up and stalls its input.
    program_regs(8'd2, 8'd3, 16'd5);
    hold_off_asked++;
    run_random(40, 1'b1);
    run_random(60, 1'b0);

    // Count ceiling, then random activity that also pulls the count back down.
    program_regs(8'd1, 8'd1, 16'd1);
    fill_count();
    run_random(50, 1'b0);

    drain();
    if (tracker.mismatches == 0) begin
      $display("tb_two_sensor_occupancy_counter_core: clean");
    end else begin
      $display("tb_two_sensor_occupancy_counter_core: errors");
    end
    $finish;
  end

endmodule
